@@ hw/rtl/cbba_pkg.sv @@
// Shared types and constants of the contiguous bitmap block allocator.
package cbba_pkg;

  localparam int unsigned MapBits   = 32768;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned MapWords  = MapBits / WordBits;
  localparam int unsigned WaddrBits = $clog2(MapWords);
  localparam int unsigned BitBits   = $clog2(WordBits);
  localparam int unsigned BlkBits   = $clog2(MapBits);
  localparam int unsigned ChunkBits = 8;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_SETFC = 2'd3
  } cbba_cmd_e;

  typedef enum logic [1:0] {
    ST_FULL = 2'd0,
    ST_PART = 2'd1,
    ST_NONE = 2'd2,
    ST_DONE = 2'd3
  } cbba_status_e;

  typedef enum logic [0:0] {
    REG_FIRST_BLOCK = 1'b0,
    REG_BLOCK_LIMIT = 1'b1
  } cbba_reg_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK_RD,
    S_MARK_WR,
    S_RESP
  } cbba_state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] run_length;
    logic [9:0]  word_index;
    logic [31:0] word_value;
    logic [15:0] free_value;
  } cbba_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] run_base;
    logic [15:0] granted;
    logic [31:0] read_word;
    logic [15:0] free_count;
  } cbba_out_t;

  typedef struct packed {
    logic [14:0] first_data_block;
    logic [31:0] block_limit;
  } cbba_cfg_t;

endpackage

@@ hw/rtl/contiguous_bitmap_block_allocator_unit.sv @@
// Top level: first-fit contiguous run allocator over a bitmap held in RAM.
// Write, read and set-count commands go through the response state to the output register.
// An allocate scans 8 blocks a cycle, one chunk of a bitmap word per step,
// then marks the run's words by read-modify-write on the RAM port, a read then a write state.
// One item is in work at a time; the output register lets the next one enter.
// After reset a clearing pass zeroes every map word, stalling input meanwhile.
module contiguous_bitmap_block_allocator_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cbba_pkg::cbba_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cbba_pkg::cbba_out_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned WB = cbba_pkg::WaddrBits;
  localparam int unsigned BB = cbba_pkg::BitBits;
  localparam int unsigned NB = cbba_pkg::BlkBits;
  localparam int unsigned CB = cbba_pkg::ChunkBits;
  localparam int unsigned CL = $clog2(CB);

  cbba_pkg::cbba_cfg_t   cfg;
  cbba_pkg::cbba_state_e state_q, state_d;

  logic [WB-1:0] clr_q;
  logic [1:0]    cmd_q;
  logic [15:0]   want_q;
  logic [NB:0]   b_q;
  logic [15:0]   run_q;
  logic [NB-1:0] rs_q;
  logic [WB-1:0] mw_q;
  logic [1:0]    status_q;
  logic [NB-1:0] start_q;
  logic [15:0]   granted_q;
  logic [15:0]   free_q;
  logic          out_valid_q;
  cbba_pkg::cbba_out_t out_q;

  logic          ram_we, ram_re;
  logic [WB-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic          accept, load;
  logic [NB:0]   end_w;
  logic          empty_win;
  logic [NB:0]   next_b;
  logic          finish;
  logic [15:0]   run_v;
  logic [NB-1:0] rs_v;
  logic          done_v;
  logic [NB-1:0] last_blk;
  logic [31:0]   mark_mask;
  logic          mark_last;

  cbba_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  cbba_ram #(.Width(cbba_pkg::WordBits), .Depth(cbba_pkg::MapWords)) u_map (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .re_i(ram_re), .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  assign accept = in_valid_i & ~in_stall_o;
  assign load   = (state_q == cbba_pkg::S_RESP) & (~out_valid_q | ~out_stall_i);

  // scan end: below the limit and below the map size
  assign end_w = (cfg.block_limit >= 32'(cbba_pkg::MapBits)) ?
                 (NB+1)'(cbba_pkg::MapBits) : cfg.block_limit[NB:0];
  assign empty_win = ({1'b0, cfg.first_data_block} >= end_w);

  // one chunk of the scan: up to 8 blocks of the current word
  always_comb begin
    logic [NB:0] blk;
    logic        used;
    run_v  = run_q;
    rs_v   = rs_q;
    done_v = 1'b0;
    for (int k = 0; k < CB; k++) begin
      blk  = {b_q[NB:CL], CL'(k)};
      used = ram_rdata[{b_q[BB-1:CL], CL'(k)}];
      if ((CL'(k) >= b_q[CL-1:0]) && (blk < end_w) && !done_v) begin
        if (!used) begin
          if (run_v == 16'd0) rs_v = blk[NB-1:0];
          run_v = run_v + 16'd1;
          if (run_v >= want_q) done_v = 1'b1;
        end else begin
          run_v = 16'd0;
        end
      end
    end
  end

  assign next_b = {b_q[NB:CL], CL'(0)} + (NB+1)'(CB);
  assign finish = done_v | (next_b >= end_w);

  // marking mask for the word at mw_q
  assign last_blk  = start_q + granted_q[NB-1:0] - NB'(1);
  assign mark_last = (mw_q == last_blk[NB-1:BB]);
  always_comb begin
    logic [BB-1:0] lo, hi;
    lo = (mw_q == start_q[NB-1:BB]) ? start_q[BB-1:0] : '0;
    hi = mark_last ? last_blk[BB-1:0] : '1;
    mark_mask = ({32{1'b1}} << lo) & ({32{1'b1}} >> (BB'(31) - hi));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cbba_pkg::S_CLEAR:   if (clr_q == '1) state_d = cbba_pkg::S_IDLE;
      cbba_pkg::S_IDLE: begin
        if (accept) begin
          if ((cbba_pkg::cbba_cmd_e'(in_data_i.cmd) == cbba_pkg::CMD_ALLOC) && !empty_win) begin
            state_d = cbba_pkg::S_SCAN;
          end else begin
            state_d = cbba_pkg::S_RESP;
          end
        end
      end
      cbba_pkg::S_SCAN: begin
        if (finish) state_d = (run_v != 16'd0) ? cbba_pkg::S_MARK_RD : cbba_pkg::S_RESP;
      end
      cbba_pkg::S_MARK_RD: state_d = cbba_pkg::S_MARK_WR;
      cbba_pkg::S_MARK_WR: state_d = mark_last ? cbba_pkg::S_RESP : cbba_pkg::S_MARK_RD;
      cbba_pkg::S_RESP:    if (load) state_d = cbba_pkg::S_IDLE;
      default:             state_d = cbba_pkg::S_CLEAR;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = mw_q;
    in_stall_o = (state_q != cbba_pkg::S_IDLE);
    unique case (state_q)
      cbba_pkg::S_CLEAR: ram_we = 1'b1;
      cbba_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cbba_pkg::cbba_cmd_e'(in_data_i.cmd))
            cbba_pkg::CMD_ALLOC: begin
              ram_re    = 1'b1;
              ram_raddr = cfg.first_data_block[NB-1:BB];
            end
            cbba_pkg::CMD_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = in_data_i.word_index;
              ram_wdata = in_data_i.word_value;
            end
            cbba_pkg::CMD_READ: begin
              ram_re    = 1'b1;
              ram_raddr = in_data_i.word_index;
            end
            default: ;
          endcase
        end
      end
      cbba_pkg::S_SCAN: begin
        if (!finish && (next_b[BB-1:0] == '0)) begin
          ram_re    = 1'b1;
          ram_raddr = next_b[NB-1:BB];
        end
      end
      cbba_pkg::S_MARK_RD: ram_re = 1'b1;
      cbba_pkg::S_MARK_WR: begin
        ram_we    = 1'b1;
        ram_waddr = mw_q;
        ram_wdata = ram_rdata | mark_mask;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbba_pkg::S_CLEAR;
      clr_q       <= '0;
      free_q      <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == cbba_pkg::S_CLEAR) clr_q <= clr_q + WB'(1);
      if (accept && (cbba_pkg::cbba_cmd_e'(in_data_i.cmd) == cbba_pkg::CMD_SETFC)) begin
        free_q <= in_data_i.free_value;
      end
      if ((state_q == cbba_pkg::S_MARK_WR) && mark_last) begin
        free_q <= (granted_q >= free_q) ? 16'd0 : free_q - granted_q;
      end
      if (load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // scan and result payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= in_data_i.cmd;
      want_q    <= (in_data_i.run_length == 16'd0) ? 16'd1 : in_data_i.run_length;
      b_q       <= {1'b0, cfg.first_data_block};
      run_q     <= 16'd0;
      rs_q      <= '0;
      start_q   <= '0;
      granted_q <= 16'd0;
      status_q  <= ((cbba_pkg::cbba_cmd_e'(in_data_i.cmd) == cbba_pkg::CMD_ALLOC) && empty_win)
                   ? cbba_pkg::ST_NONE : cbba_pkg::ST_DONE;
    end
    if (state_q == cbba_pkg::S_SCAN) begin
      b_q   <= next_b;
      run_q <= run_v;
      rs_q  <= rs_v;
      if (finish) begin
        mw_q <= rs_v[NB-1:BB];
        if (run_v != 16'd0) begin
          status_q  <= done_v ? cbba_pkg::ST_FULL : cbba_pkg::ST_PART;
          start_q   <= rs_v;
          granted_q <= run_v;
        end else begin
          status_q <= cbba_pkg::ST_NONE;
        end
      end
    end
    if (state_q == cbba_pkg::S_MARK_WR) mw_q <= mw_q + WB'(1);
    if (load) begin
      out_q.status      <= status_q;
      out_q.run_base    <= start_q;
      out_q.granted     <= granted_q;
      out_q.read_word   <= (cbba_pkg::cbba_cmd_e'(cmd_q) == cbba_pkg::CMD_READ) ?
                           ram_rdata : 32'd0;
      out_q.free_count  <= free_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("map RAM read and write in the same cycle");
  a_mark_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbba_pkg::S_MARK_WR) |-> ($past(state_q) == cbba_pkg::S_MARK_RD))
    else $error("mark write without its read");
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbba_pkg::S_SCAN) |-> (run_q < want_q))
    else $error("scan run exceeded the request");
  a_load_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_q && (state_q == cbba_pkg::S_IDLE)))
    else $error("result load did not present a transfer");

endmodule

@@ hw/rtl/cbba_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module cbba_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/cbba_cfg.sv @@
// APB-style configuration registers of the allocator.
module cbba_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cbba_pkg::cbba_cfg_t cfg_o
);

  logic [14:0] first_q, first_d;
  logic [31:0] limit_q, limit_d;
  logic        wr;

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  // register write decode
  always_comb begin
    first_d = first_q;
    limit_d = limit_q;
    if (wr) begin
      unique case (cbba_pkg::cbba_reg_e'(paddr[2]))
        cbba_pkg::REG_FIRST_BLOCK: first_d = pwdata[14:0];
        cbba_pkg::REG_BLOCK_LIMIT: limit_d = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 15'd0;
      limit_q <= 32'd32768;
    end else begin
      first_q <= first_d;
      limit_q <= limit_d;
    end
  end

  // read back
  always_comb begin
    unique case (cbba_pkg::cbba_reg_e'(paddr[2]))
      cbba_pkg::REG_FIRST_BLOCK: prdata = {17'd0, first_q};
      cbba_pkg::REG_BLOCK_LIMIT: prdata = limit_q;
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg_o.first_data_block = first_q;
  assign cfg_o.block_limit      = limit_q;

endmodule
